// ----- hw/rtl/dvi_command_framer_core_macros.svh -----
// Assertion helpers shared by the framer RTL.
// Each macro expects clk and arst_n in scope.
`ifndef DVI_COMMAND_FRAMER_CORE_MACROS_SVH
`define DVI_COMMAND_FRAMER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DCF_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define DCF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dcf_pkg.sv -----
`timescale 1ns / 1ps
package dcf_pkg;

	// opcode landmarks
	localparam logic [7:0] PRINT_LO        = 8'd32;
	localparam logic [7:0] PRINT_HI        = 8'd126;
	localparam logic [7:0] OP_GRP_FIRST    = 8'd128;
	localparam logic [7:0] OP_GRP_LAST     = 8'd170;
	localparam logic [7:0] OP_FNT_NUM_LAST = 8'd234;
	localparam logic [7:0] OP_FNT4         = 8'd238;
	localparam logic [7:0] OP_XXX4         = 8'd242;
	localparam logic [7:0] OP_FNT_DEF4     = 8'd246;
	localparam logic [7:0] OP_PRE          = 8'd247;
	localparam logic [7:0] OP_POST         = 8'd248;
	localparam logic [7:0] OP_POST_POST    = 8'd249;
	localparam logic [7:0] PAD_BYTE        = 8'd223;

	// fixed header sizes
	localparam logic [5:0] FNT_DEF_FIXED = 6'd14;
	localparam logic [5:0] PRE_HDR       = 6'd14;
	localparam logic [5:0] POST_HDR      = 6'd28;
	localparam logic [5:0] PP_HDR        = 6'd5;
	localparam logic [2:0] PW_MAX        = 3'd4;

	localparam int ITEM_DEPTH = 4;
	localparam int ITEM_PTR_W = $clog2(ITEM_DEPTH);
	localparam int ITEM_CNT_W = $clog2(ITEM_DEPTH + 1);
	localparam int RES_DEPTH  = 4;
	localparam int RES_PTR_W  = $clog2(RES_DEPTH);
	localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

	// header bytes after the opcode, opcodes 128..170
	localparam logic [5:0] GRP_HDR [43] = '{
		6'd1, 6'd2, 6'd3, 6'd4, 6'd8, 6'd1, 6'd2, 6'd3, 6'd4, 6'd8, 6'd0,
		6'd44, 6'd0, 6'd0, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd0, 6'd1, 6'd2,
		6'd3, 6'd4, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd1, 6'd2, 6'd3, 6'd4,
		6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4};

	// first parameter signed, opcodes 128..170
	localparam logic GRP_PS [43] = '{
		1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
		1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
		1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
		1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

	// what follows the header
	typedef enum logic [2:0] {
		TK_NONE,
		TK_VALUE,
		TK_FONT,
		TK_BYTE,
		TK_PAD
	} tail_kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_PAD_SHORT,
		ST_PAD_LATE,
		ST_TRUNC
	} status_t;

	typedef struct packed {
		logic [5:0] hdr;
		logic [2:0] pw;
		logic       ps;
		tail_kind_t kind;
	} layout_t;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       eos;
		logic       printable;
		logic       is_pad;
		layout_t    lay;
	} item_t;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [32:0] length;
		logic [32:0] param;
		status_t     status;
		logic        last;
	} result_t;

	function automatic layout_t op_layout(logic [7:0] op);
		layout_t l;
		l.hdr  = '0;
		l.pw   = '0;
		l.ps   = 1'b0;
		l.kind = TK_NONE;
		case (op) inside
			[OP_GRP_FIRST:OP_GRP_LAST]: begin
				l.hdr = GRP_HDR[op[5:0]];
				l.pw  = (l.hdr > 6'(PW_MAX)) ? PW_MAX : l.hdr[2:0];
				l.ps  = GRP_PS[op[5:0]];
			end
			[OP_FNT_NUM_LAST + 8'd1:OP_FNT4]: begin
				l.hdr = 6'(op - OP_FNT_NUM_LAST);
				l.pw  = 3'(op - OP_FNT_NUM_LAST);
				l.ps  = (op == OP_FNT4);
			end
			[OP_FNT4 + 8'd1:OP_XXX4]: begin
				l.hdr  = 6'(op - OP_FNT4);
				l.pw   = 3'(op - OP_FNT4);
				l.kind = TK_VALUE;
			end
			[OP_XXX4 + 8'd1:OP_FNT_DEF4]: begin
				l.hdr  = 6'(op - OP_XXX4) + FNT_DEF_FIXED;
				l.pw   = 3'(op - OP_XXX4);
				l.ps   = (op == OP_FNT_DEF4);
				l.kind = TK_FONT;
			end
			OP_PRE: begin
				l.hdr  = PRE_HDR;
				l.pw   = 3'd1;
				l.kind = TK_BYTE;
			end
			OP_POST: begin
				l.hdr = POST_HDR;
				l.pw  = PW_MAX;
			end
			OP_POST_POST: begin
				l.hdr  = PP_HDR;
				l.pw   = PW_MAX;
				l.kind = TK_PAD;
			end
			default: begin
				l.hdr = '0;
			end
		endcase
		return l;
	endfunction

	function automatic logic [32:0] sat_inc(logic [32:0] v);
		return (&v) ? v : v + 33'd1;
	endfunction

	// sign- or zero-extend a completed first parameter of pw bytes
	function automatic logic [32:0] first_param(logic [31:0] v, logic [2:0] pw, logic ps);
		logic [32:0] r;
		case (pw)
			3'd1:    r = {{25{ps & v[7]}}, v[7:0]};
			3'd2:    r = {{17{ps & v[15]}}, v[15:0]};
			3'd3:    r = {{9{ps & v[23]}}, v[23:0]};
			default: r = {ps & v[31], v};
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/dvi_command_framer_core.sv -----
`timescale 1ns / 1ps
// DVI command framer: cuts a DVI byte stream into commands.
// Input channel: one stream byte per item (data_byte), or an end-of-stream
// marker (end_of_stream high, byte ignored). An item is taken on a clock
// edge with push high and full low.
// Result channel: while empty is low the oldest command is on the result
// ports; pop high on a clock edge takes it. Each item gives zero, one or two
// results; last_result marks the final one of an item.
// A result passes through the item queue and then the result queue, both
// registered, before it reaches the result ports.
// Throughput: one item per cycle; the parser takes an item only when the
// 4-entry result queue has room for two results, so with pop held high the
// input never stalls.
// Between the byte classifier and the parser sits a 4-entry item queue, so
// full rises only when the receiver stalls long enough to back up both
// queues. Reset empties both queues and returns the parser to idle.
module dvi_command_framer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               end_of_stream,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         command_opcode,
	output logic [32:0]        command_length,
	output logic signed [32:0] param_value,
	output logic [1:0]         status,
	output logic               last_result
);

	logic              head_valid;
	dcf_pkg::item_t    head;
	logic              take;
	logic              room;
	logic [1:0]        res_num;
	dcf_pkg::result_t  res [2];
	dcf_pkg::result_t  out_head;

	dcf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.head_valid   (head_valid),
		.head         (head),
		.take         (take)
	);

	dcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.room      (room),
		.take      (take),
		.res_num   (res_num),
		.res       (res)
	);

	dcf_result_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_num (res_num),
		.wr_data(res),
		.room   (room),
		.empty  (empty),
		.pop    (pop),
		.head   (out_head)
	);

	assign command_opcode = out_head.opcode;
	assign command_length = out_head.length;
	assign param_value    = $signed(out_head.param);
	assign status         = out_head.status;
	assign last_result    = out_head.last;

endmodule

// ----- hw/rtl/dcf_front.sv -----
`timescale 1ns / 1ps
module dcf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      data_byte,
	input  logic            end_of_stream,
	output logic            head_valid,
	output dcf_pkg::item_t  head,
	input  logic            take
);

	dcf_pkg::item_t                   cls;
	dcf_pkg::item_t                   mem_q [dcf_pkg::ITEM_DEPTH];
	logic [dcf_pkg::ITEM_PTR_W-1:0]   wr_ptr_q;
	logic [dcf_pkg::ITEM_PTR_W-1:0]   rd_ptr_q;
	logic [dcf_pkg::ITEM_CNT_W-1:0]   count_q;
	logic                             do_push;
	logic                             do_take;

	// classify the byte on the way in
	always_comb begin
		cls.byte_val  = data_byte;
		cls.eos       = end_of_stream;
		cls.printable = (data_byte >= dcf_pkg::PRINT_LO) && (data_byte <= dcf_pkg::PRINT_HI);
		cls.is_pad    = (data_byte == dcf_pkg::PAD_BYTE);
		cls.lay       = dcf_pkg::op_layout(data_byte);
	end

	assign full       = (count_q == dcf_pkg::ITEM_CNT_W'(dcf_pkg::ITEM_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_take    = take && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + dcf_pkg::ITEM_PTR_W'(1);
			end
			if (do_take) begin
				rd_ptr_q <= rd_ptr_q + dcf_pkg::ITEM_PTR_W'(1);
			end
			count_q <= count_q + dcf_pkg::ITEM_CNT_W'(do_push) - dcf_pkg::ITEM_CNT_W'(do_take);
		end
	end

endmodule

// ----- hw/rtl/dcf_result_fifo.sv -----
`timescale 1ns / 1ps
module dcf_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        wr_num,
	input  dcf_pkg::result_t  wr_data [2],
	output logic              room,
	output logic              empty,
	input  logic              pop,
	output dcf_pkg::result_t  head
);

	dcf_pkg::result_t                mem_q [dcf_pkg::RES_DEPTH];
	logic [dcf_pkg::RES_PTR_W-1:0]   wr_ptr_q;
	logic [dcf_pkg::RES_PTR_W-1:0]   rd_ptr_q;
	logic [dcf_pkg::RES_CNT_W-1:0]   count_q;
	logic                            do_pop;

	// room for a full two-result burst
	assign room   = (count_q <= dcf_pkg::RES_CNT_W'(dcf_pkg::RES_DEPTH - 2));
	assign empty  = (count_q == '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_num != 2'd0) begin
			mem_q[wr_ptr_q] <= wr_data[0];
		end
		if (wr_num == 2'd2) begin
			mem_q[wr_ptr_q + dcf_pkg::RES_PTR_W'(1)] <= wr_data[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + dcf_pkg::RES_PTR_W'(wr_num);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + dcf_pkg::RES_PTR_W'(1);
			end
			count_q <= count_q + dcf_pkg::RES_CNT_W'(wr_num) - dcf_pkg::RES_CNT_W'(do_pop);
		end
	end

endmodule

// ----- hw/rtl/dcf_back.sv -----
`timescale 1ns / 1ps
`include "dvi_command_framer_core_macros.svh"
module dcf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  dcf_pkg::item_t    head,
	input  logic              room,
	output logic              take,
	output logic [1:0]        res_num,
	output dcf_pkg::result_t  res [2]
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RUN,
		PH_FIELDS,
		PH_SKIP,
		PH_PAD
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [7:0]           held_q, held_n;
	logic [31:0]          btg_q, btg_n;
	logic [2:0]           fi_q, fi_n;
	logic [31:0]          vacc_q, vacc_n;
	logic [32:0]          first_q, first_n;
	logic [32:0]          len_q, len_n;
	logic [7:0]           area_q, area_n;
	logic [2:0]           pad_q, pad_n;
	logic [2:0]           pw_q, pw_n;
	logic                 ps_q, ps_n;
	dcf_pkg::tail_kind_t  kind_q, kind_n;

	logic                 pre_v, st_v, do_start;
	dcf_pkg::result_t     pre_r, st_r;
	logic [31:0]          tail;
	logic [7:0]           b;

	assign take = head_valid && room;
	assign b    = head.byte_val;

	always_comb begin
		phase_n  = phase_q;
		held_n   = held_q;
		btg_n    = btg_q;
		fi_n     = fi_q;
		vacc_n   = vacc_q;
		first_n  = first_q;
		len_n    = len_q;
		area_n   = area_q;
		pad_n    = pad_q;
		pw_n     = pw_q;
		ps_n     = ps_q;
		kind_n   = kind_q;
		pre_v    = 1'b0;
		pre_r    = '{opcode: held_q, length: len_q, param: '0,
			status: dcf_pkg::ST_OK, last: 1'b0};
		st_v     = 1'b0;
		st_r     = '{opcode: b, length: 33'd1, param: '0,
			status: dcf_pkg::ST_OK, last: 1'b0};
		do_start = 1'b0;
		tail     = '0;

		if (head.eos) begin
			phase_n = PH_IDLE;
			case (phase_q)
				PH_RUN: begin
					pre_v = 1'b1;
				end
				PH_FIELDS, PH_SKIP: begin
					pre_v        = 1'b1;
					pre_r.param  = (fi_q == 3'd0) ? first_q : '0;
					pre_r.status = dcf_pkg::ST_TRUNC;
				end
				PH_PAD: begin
					pre_v        = 1'b1;
					pre_r.param  = first_q;
					pre_r.status = (pad_q < 3'd4) ? dcf_pkg::ST_PAD_SHORT : dcf_pkg::ST_OK;
				end
				default: begin
					pre_v = 1'b0;
				end
			endcase
		end else begin
			case (phase_q)
				PH_RUN: begin
					if (head.printable) begin
						len_n = dcf_pkg::sat_inc(len_q);
					end else begin
						pre_v    = 1'b1;
						do_start = 1'b1;
					end
				end
				PH_FIELDS: begin
					len_n = dcf_pkg::sat_inc(len_q);
					if (fi_q != 3'd0) begin
						vacc_n = {vacc_q[23:0], b};
						fi_n   = fi_q - 3'd1;
						if (fi_q == 3'd1) begin
							first_n = dcf_pkg::first_param(vacc_n, pw_q, ps_q);
						end
					end
					// font area length sits two bytes before the header end
					if (kind_q == dcf_pkg::TK_FONT && btg_q == 32'd2) begin
						area_n = b;
					end
					if (btg_q != 32'd0) begin
						btg_n = btg_q - 32'd1;
					end
					if (btg_n == 32'd0) begin
						case (kind_q)
							dcf_pkg::TK_VALUE: tail = vacc_n;
							dcf_pkg::TK_FONT:  tail = 32'(area_q) + 32'(b);
							dcf_pkg::TK_BYTE:  tail = 32'(b);
							default:           tail = '0;
						endcase
						if (kind_q == dcf_pkg::TK_PAD) begin
							phase_n = PH_PAD;
							pad_n   = '0;
						end else if (tail != 32'd0) begin
							phase_n = PH_SKIP;
							btg_n   = tail;
						end else begin
							phase_n      = PH_IDLE;
							pre_v        = 1'b1;
							pre_r.length = len_n;
							pre_r.param  = first_n;
						end
					end
				end
				PH_SKIP: begin
					len_n = dcf_pkg::sat_inc(len_q);
					if (btg_q != 32'd0) begin
						btg_n = btg_q - 32'd1;
					end
					if (btg_n == 32'd0) begin
						phase_n      = PH_IDLE;
						pre_v        = 1'b1;
						pre_r.length = len_n;
						pre_r.param  = first_q;
					end
				end
				PH_PAD: begin
					if (head.is_pad) begin
						len_n = dcf_pkg::sat_inc(len_q);
						if (pad_q != 3'd7) begin
							pad_n = pad_q + 3'd1;
						end
					end else begin
						pre_v        = 1'b1;
						pre_r.param  = first_q;
						pre_r.status = (pad_q < 3'd4) ? dcf_pkg::ST_PAD_SHORT
							: dcf_pkg::ST_PAD_LATE;
						do_start     = 1'b1;
					end
				end
				default: begin
					do_start = 1'b1;
				end
			endcase

			// this byte opens a new command
			if (do_start) begin
				phase_n = PH_IDLE;
				if (!b[7]) begin
					if (head.printable) begin
						phase_n = PH_RUN;
						held_n  = b;
						len_n   = 33'd1;
					end else begin
						st_v = 1'b1;
					end
				end else if (head.lay.hdr == 6'd0) begin
					st_v = 1'b1;
				end else begin
					phase_n = PH_FIELDS;
					held_n  = b;
					len_n   = 33'd1;
					vacc_n  = '0;
					first_n = '0;
					area_n  = '0;
					pad_n   = '0;
					fi_n    = head.lay.pw;
					btg_n   = 32'(head.lay.hdr);
					pw_n    = head.lay.pw;
					ps_n    = head.lay.ps;
					kind_n  = head.lay.kind;
				end
			end
		end
	end

	// pack the results; the last one of the item carries the flag
	always_comb begin
		res[0]  = pre_v ? pre_r : st_r;
		res[1]  = st_r;
		res_num = 2'(pre_v) + 2'(st_v);
		if (!take) begin
			res_num = 2'd0;
		end
		res[0].last = (res_num == 2'd1);
		res[1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
			btg_q   <= '0;
			fi_q    <= '0;
			vacc_q  <= '0;
			first_q <= '0;
			len_q   <= '0;
			area_q  <= '0;
			pad_q   <= '0;
			pw_q    <= '0;
			ps_q    <= 1'b0;
			kind_q  <= dcf_pkg::TK_NONE;
		end else if (take) begin
			phase_q <= phase_n;
			held_q  <= held_n;
			btg_q   <= btg_n;
			fi_q    <= fi_n;
			vacc_q  <= vacc_n;
			first_q <= first_n;
			len_q   <= len_n;
			area_q  <= area_n;
			pad_q   <= pad_n;
			pw_q    <= pw_n;
			ps_q    <= ps_n;
			kind_q  <= kind_n;
		end
	end

	`DCF_ASSERT_SAME(a_res_needs_take, res_num != 2'd0, take, "result without an item")
	`DCF_ASSERT_SAME(a_two_last, res_num == 2'd2, !res[0].last && res[1].last, "last flag misplaced")
	`DCF_ASSERT_SAME(a_pad_status, res_num != 2'd0 && (res[0].status == dcf_pkg::ST_PAD_SHORT || res[0].status == dcf_pkg::ST_PAD_LATE), res[0].opcode == dcf_pkg::OP_POST_POST, "pad status on other opcode")
	`DCF_ASSERT_SAME(a_fields_live, phase_q == PH_FIELDS, btg_q != 32'd0 && fi_q <= 3'd4, "header counters out of range")
	`DCF_ASSERT_NEXT(a_eos_idle, take && head.eos, phase_q == PH_IDLE, "not idle after end of stream")

endmodule

// ----- verif/dvi_command_framer_core_tb.sv -----
`timescale 1ns / 1ps
module dvi_command_framer_core_tb;
	import dcf_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_SLACK = 12;

	localparam logic [7:0] OP_NOP    = 8'd138;
	localparam logic [7:0] OP_BOP    = 8'd139;
	localparam logic [7:0] OP_RIGHT1 = 8'd143;
	localparam logic [7:0] OP_FNT1   = OP_FNT_NUM_LAST + 8'd1;
	localparam logic [7:0] OP_XXX1   = OP_FNT4 + 8'd1;
	localparam logic [7:0] OP_FDEF1  = OP_XXX4 + 8'd1;

	// header bytes and first-parameter width for 128..170, negative width = signed
	localparam int SET_HDR [43] = '{
		1, 2, 3, 4, 8, 1, 2, 3, 4, 8, 0, 44, 0, 0, 0, 1, 2, 3, 4, 0, 1, 2,
		3, 4, 0, 1, 2, 3, 4, 1, 2, 3, 4, 0, 1, 2, 3, 4, 0, 1, 2, 3, 4};
	localparam int SET_PARAM [43] = '{
		1, 2, 3, -4, -4, 1, 2, 3, -4, -4, 0, -4, 0, 0, 0, -1, -2, -3, -4, 0, -1, -2,
		-3, -4, 0, -1, -2, -3, -4, -1, -2, -3, -4, 0, -1, -2, -3, -4, 0, -1, -2, -3, -4};

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_RUN,
		FR_HEADER,
		FR_SKIP,
		FR_PAD
	} frame_phase_e;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SLOW,
		RX_BEAT
	} rx_mode_e;

	class command_scoreboard;
		frame_phase_e ph;
		bit [7:0]     op_h;
		bit [31:0]    togo;
		int           fidx;
		bit [31:0]    vacc;
		bit [32:0]    fval;
		bit [32:0]    len;
		bit [7:0]     area;
		int           pads;
		result_t      want[$];
		result_t      fresh[$];
		int           errors;
		int           items;
		int           per_status[4];

		function new();
			ph = FR_IDLE;
			op_h = '0;
			togo = '0;
			fidx = 0;
			vacc = '0;
			fval = '0;
			len = '0;
			area = '0;
			pads = 0;
			errors = 0;
			items = 0;
			foreach (per_status[i]) per_status[i] = 0;
		endfunction

		function void shape(input bit [7:0] op, output int hdr, output int pw, output bit sgn);
			int code;
			hdr = 0;
			pw = 0;
			sgn = 1'b0;
			if (op >= OP_GRP_FIRST && op <= OP_GRP_LAST) begin
				code = SET_PARAM[op - OP_GRP_FIRST];
				hdr = SET_HDR[op - OP_GRP_FIRST];
				pw = code < 0 ? -code : code;
				sgn = code < 0;
			end else if (op > OP_FNT_NUM_LAST && op <= OP_FNT4) begin
				hdr = int'(op) - int'(OP_FNT_NUM_LAST);
				pw = hdr;
				sgn = (op == OP_FNT4);
			end else if (op > OP_FNT4 && op <= OP_XXX4) begin
				hdr = int'(op) - int'(OP_FNT4);
				pw = hdr;
			end else if (op > OP_XXX4 && op <= OP_FNT_DEF4) begin
				pw = int'(op) - int'(OP_XXX4);
				hdr = pw + int'(FNT_DEF_FIXED);
				sgn = (op == OP_FNT_DEF4);
			end else if (op == OP_PRE) begin
				hdr = int'(PRE_HDR);
				pw = 1;
			end else if (op == OP_POST) begin
				hdr = int'(POST_HDR);
				pw = 4;
			end else if (op == OP_POST_POST) begin
				hdr = int'(PP_HDR);
				pw = 4;
			end
		endfunction

		function bit [32:0] bump(bit [32:0] v);
			return (&v) ? v : v + 33'd1;
		endfunction

		function void emit_cmd(bit [7:0] op, bit [32:0] l, bit [32:0] p, status_t st);
			result_t r;
			if (fresh.size() >= 2) return;
			r.opcode = op;
			r.length = l;
			r.param = p;
			r.status = st;
			r.last = 1'b0;
			fresh.push_back(r);
		endfunction

		function void close_cmd(status_t st);
			emit_cmd(op_h, len, fval, st);
			ph = FR_IDLE;
		endfunction

		function void open_cmd(bit [7:0] b);
			int hdr, pw;
			bit sgn;
			ph = FR_IDLE;
			if (b < OP_GRP_FIRST) begin
				if (b >= PRINT_LO && b <= PRINT_HI) begin
					ph = FR_RUN;
					op_h = b;
					len = 33'd1;
				end else begin
					emit_cmd(b, 33'd1, '0, ST_OK);
				end
				return;
			end
			shape(b, hdr, pw, sgn);
			if (hdr == 0) begin
				emit_cmd(b, 33'd1, '0, ST_OK);
				return;
			end
			ph = FR_HEADER;
			op_h = b;
			len = 33'd1;
			vacc = '0;
			fval = '0;
			area = '0;
			pads = 0;
			fidx = pw;
			togo = hdr;
		endfunction

		function void take_header(bit [7:0] b);
			int hdr, pw, pos;
			bit sgn;
			bit [31:0] tail;
			bit [32:0] v, keep;
			shape(op_h, hdr, pw, sgn);
			tail = '0;
			len = bump(len);
			if (fidx > 0 && fidx <= 4) begin
				vacc = {vacc[23:0], b};
				fidx--;
				if (fidx == 0) begin
					v = {1'b0, vacc};
					keep = (33'd1 << (8 * pw)) - 33'd1;
					if (sgn && vacc[8 * pw - 1]) v = v | ~keep;
					fval = v;
				end
			end
			pos = (togo <= hdr) ? hdr - int'(togo) : 0;
			// area length byte sits just before the name length byte
			if (op_h > OP_XXX4 && op_h <= OP_FNT_DEF4 &&
			    pos == int'(op_h) - int'(OP_XXX4) + 12)
				area = b;
			if (togo > 0) togo--;
			if (togo != 0) return;
			if (op_h > OP_FNT4 && op_h <= OP_XXX4) tail = vacc;
			else if (op_h > OP_XXX4 && op_h <= OP_FNT_DEF4) tail = area + b;
			else if (op_h == OP_PRE) tail = b;
			if (op_h == OP_POST_POST) begin
				ph = FR_PAD;
				pads = 0;
			end else if (tail != 0) begin
				ph = FR_SKIP;
				togo = tail;
			end else begin
				close_cmd(ST_OK);
			end
		endfunction

		function void note_input(bit [7:0] b, bit eos);
			fresh.delete();
			items++;
			if (eos) begin
				case (ph)
					FR_RUN: emit_cmd(op_h, len, '0, ST_OK);
					FR_HEADER, FR_SKIP: emit_cmd(op_h, len, fidx == 0 ? fval : '0, ST_TRUNC);
					FR_PAD: emit_cmd(op_h, len, fval, pads < 4 ? ST_PAD_SHORT : ST_OK);
					default: ;
				endcase
				ph = FR_IDLE;
			end else begin
				case (ph)
					FR_RUN: begin
						if (b >= PRINT_LO && b <= PRINT_HI) begin
							len = bump(len);
						end else begin
							emit_cmd(op_h, len, '0, ST_OK);
							open_cmd(b);
						end
					end
					FR_HEADER: take_header(b);
					FR_SKIP: begin
						len = bump(len);
						if (togo > 0) togo--;
						if (togo == 0) close_cmd(ST_OK);
					end
					FR_PAD: begin
						if (b == PAD_BYTE) begin
							len = bump(len);
							if (pads < 7) pads++;
						end else begin
							close_cmd(pads < 4 ? ST_PAD_SHORT : ST_PAD_LATE);
							open_cmd(b);
						end
					end
					default: open_cmd(b);
				endcase
			end
			if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
			foreach (fresh[i]) want.push_back(fresh[i]);
		endfunction

		function void check_result(bit [7:0] op, bit [32:0] l, bit [32:0] p, bit [1:0] st,
		                           bit lst);
			result_t w;
			if (want.size() == 0) begin
				$error("command with no expectation: opcode %0h length %0d", op, l);
				errors++;
				return;
			end
			w = want.pop_front();
			per_status[w.status]++;
			if (op !== w.opcode) begin
				$error("command_opcode expected %0h got %0h", w.opcode, op);
				errors++;
			end
			if (l !== w.length) begin
				$error("command_length expected %0d got %0d", w.length, l);
				errors++;
			end
			if (p !== w.param) begin
				$error("param_value expected %09h got %09h", w.param, p);
				errors++;
			end
			if (st !== w.status) begin
				$error("status expected %0d got %0d", w.status, st);
				errors++;
			end
			if (lst !== w.last) begin
				$error("last_result expected %0b got %0b", w.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [7:0]         data_byte = '0;
	logic               end_of_stream = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic [7:0]         command_opcode;
	logic [32:0]        command_length;
	logic signed [32:0] param_value;
	logic [1:0]         status;
	logic               last_result;

	command_scoreboard sb;
	bit [8:0] plan[$];
	int       burst_left = 0;
	int       sent = 0;
	int       cycles = 0;
	rx_mode_e rx_mode = RX_FREE;
	int       rx_left = 0;

	dvi_command_framer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.empty(empty),
		.pop(pop),
		.command_opcode(command_opcode),
		.command_length(command_length),
		.param_value(param_value),
		.status(status),
		.last_result(last_result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note_input(data_byte, end_of_stream);
			if (pop && !empty)
				sb.check_result(command_opcode, command_length, param_value, status,
				                last_result);
		end
	end

	// receiver: switches between free flow, coin flips, long stalls and a fixed beat
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		case (rx_mode)
			RX_FREE: pop <= 1'b1;
			RX_COIN: pop <= 1'($urandom_range(0, 1));
			RX_SLOW: pop <= ($urandom_range(0, 7) == 0);
			default: pop <= ((cycles % 16) < 11);
		endcase
	end

	function automatic void plan_byte(bit [7:0] b);
		plan.push_back({1'b0, b});
	endfunction

	function automatic void plan_eos();
		plan.push_back({1'b1, 8'(Sa_rand())});
	endfunction

	function automatic int Sa_rand();
		return $urandom_range(0, 255);
	endfunction

	// one command, well formed unless cut short by an end of stream
	function automatic void plan_command();
		bit [8:0] part[$];
		bit [7:0] op;
		int hdr, pw, k, n, pick, cut;
		bit sgn;
		pick = $urandom_range(0, 9);
		if (pick < 4) op = 8'($urandom_range(0, 255));
		else if (pick < 6) op = 8'($urandom_range(PRINT_LO, PRINT_HI));
		else if ($urandom_range(0, 12) == 0) op = OP_BOP;
		else op = 8'($urandom_range(OP_FNT1, OP_POST_POST));
		part.push_back({1'b0, op});
		if (op >= PRINT_LO && op <= PRINT_HI) begin
			n = $urandom_range(0, 15);
			repeat (n) part.push_back({1'b0, 8'($urandom_range(PRINT_LO, PRINT_HI))});
		end else begin
			sb.shape(op, hdr, pw, sgn);
			if (op >= OP_XXX1 && op <= OP_XXX4) begin
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 6);
				for (int i = pw - 1; i >= 0; i--) part.push_back({1'b0, 8'(k >> (8 * i))});
				repeat (k) part.push_back({1'b0, 8'(Sa_rand())});
			end else if (op >= OP_FDEF1 && op <= OP_FNT_DEF4) begin
				repeat (pw + 12) part.push_back({1'b0, 8'(Sa_rand())});
				k = $urandom_range(0, 4);
				n = $urandom_range(0, 6);
				part.push_back({1'b0, 8'(k)});
				part.push_back({1'b0, 8'(n)});
				repeat (k + n) part.push_back({1'b0, 8'(Sa_rand())});
			end else if (op == OP_PRE) begin
				repeat (hdr - 1) part.push_back({1'b0, 8'(Sa_rand())});
				k = $urandom_range(0, 8);
				part.push_back({1'b0, 8'(k)});
				repeat (k) part.push_back({1'b0, 8'(Sa_rand())});
			end else if (op == OP_POST_POST) begin
				repeat (hdr) part.push_back({1'b0, 8'(Sa_rand())});
				pick = $urandom_range(0, 5);
				n = pick == 0 ? $urandom_range(0, 3) :
				    pick == 1 ? $urandom_range(8, 12) : $urandom_range(4, 7);
				repeat (n) part.push_back({1'b0, PAD_BYTE});
			end else begin
				repeat (hdr) part.push_back({1'b0, 8'(Sa_rand())});
			end
		end
		if (part.size() > 1 && $urandom_range(0, 14) == 0) begin
			cut = $urandom_range(1, part.size() - 1);
			part = part[0:cut - 1];
			part.push_back({1'b1, 8'(Sa_rand())});
		end else if ($urandom_range(0, 24) == 0) begin
			part.push_back({1'b1, 8'(Sa_rand())});
		end
		// occasional garbage, always closed by an end of stream
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 4)) part.push_back({1'b0, 8'(Sa_rand())});
			part.push_back({1'b1, 8'(Sa_rand())});
		end
		foreach (part[i]) plan.push_back(part[i]);
	endfunction

	task automatic send_item(bit [7:0] b, bit eos);
		push <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic pause(int n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic feed_plan();
		bit [8:0] it;
		while (plan.size() > 0) begin
			it = plan.pop_front();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
			end
			burst_left--;
			send_item(it[7:0], it[8]);
			sent++;
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.want.size() != 0) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle eos, byte extremes, run ended by a one-byte command,
		// signed and unsigned params, a special, short padding at eos,
		// run at eos, header cut short
		plan_eos();
		plan_byte(8'h00);
		plan_byte(8'hFF);
		plan_byte("A");
		plan_byte(PRINT_HI);
		plan_byte(OP_NOP);
		plan_byte(OP_FNT1);
		plan_byte(8'h80);
		plan_byte(OP_RIGHT1);
		plan_byte(8'hFF);
		plan_byte(OP_XXX1);
		plan_byte(8'h02);
		plan_byte(8'h11);
		plan_byte(8'h22);
		plan_byte(OP_POST_POST);
		repeat (5) plan_byte(8'h5A);
		plan_byte(PAD_BYTE);
		plan_byte(PAD_BYTE);
		plan_eos();
		plan_byte(PRINT_LO);
		plan_eos();
		plan_byte(OP_FNT4);
		plan_byte(8'h12);
		plan_byte(8'h34);
		plan_eos();
		feed_plan();
		drain();

		while (sent < RANDOM_ITEMS + 30) begin
			plan_command();
			feed_plan();
			if ($urandom_range(0, 149) == 0) drain();
		end

		drain();
		repeat (DRAIN_SLACK) @(posedge clk);
		$display("%0d stream items framed into %0d commands", sb.items,
		         sb.per_status[ST_OK] + sb.per_status[ST_PAD_SHORT] +
		         sb.per_status[ST_PAD_LATE] + sb.per_status[ST_TRUNC]);
		$display("  truncated %0d, short padding %0d, late padding %0d",
		         sb.per_status[ST_TRUNC], sb.per_status[ST_PAD_SHORT],
		         sb.per_status[ST_PAD_LATE]);
		if (sb.errors == 0 && sb.want.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
